### rtl/itaf_pkg.sv
package itaf_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned COUNT_W    = 31;
  localparam int unsigned DEC_BITS   = 32;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [2:0] MODE_SDEC  = 3'd0;
  localparam logic [2:0] MODE_UDEC  = 3'd1;
  localparam logic [2:0] MODE_HEXL  = 3'd2;
  localparam logic [2:0] MODE_HEXU  = 3'd3;
  localparam logic [2:0] MODE_PTR   = 3'd4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  typedef struct packed {
    logic [2:0]         mode;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count_in;
  } req_t;

  typedef struct packed {
    logic [7:0]         char_code;
    logic [COUNT_W-1:0] count_out;
    logic               last_char;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_PREFIX,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_MINUS,
    PFX_HEX,
    PFX_NIL
  } pfx_e;

  function automatic logic [2:0] pfx_len(input pfx_e kind);
    logic [2:0] len;
    unique case (kind)
      PFX_MINUS: len = 3'd1;
      PFX_HEX:   len = 3'd2;
      PFX_NIL:   len = 3'd5;
      default:   len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] pfx_char(input pfx_e kind, input logic [2:0] idx);
    logic [7:0] ch;
    ch = CH_MINUS;
    unique case (kind)
      PFX_HEX: ch = (idx == 3'd0) ? CH_ZERO : 8'h78;
      PFX_NIL: begin
        unique case (idx)
          3'd0:    ch = 8'h28;
          3'd1:    ch = 8'h6e;
          3'd2:    ch = 8'h69;
          3'd3:    ch = 8'h6c;
          default: ch = 8'h29;
        endcase
      end
      default: ch = CH_MINUS;
    endcase
    return ch;
  endfunction

endpackage

### rtl/itaf_bcd_conv.sv
module itaf_bcd_conv (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [itaf_pkg::DEC_BITS-1:0]  bin_i,
  output logic                           done_o,
  output logic [itaf_pkg::BCD_W-1:0]     bcd_o
);
  import itaf_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEC_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DEC_BITS - 1);

  logic             run_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEC_BITS-1:0] bin_q;
  logic [BCD_W-1:0]    bcd_q, adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == CNT_LAST);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= bin_i;
      bcd_q <= '0;
    end else if (run_q) begin
      bin_q <= {bin_q[DEC_BITS-2:0], 1'b0};
      bcd_q <= {adj[BCD_W-2:0], bin_q[DEC_BITS-1]};
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

### rtl/integer_to_ascii_formatter_core.sv
// Channel  | Handshake          | Payload  | Direction
// request  | start_i / busy_o   | req_i    | in
// result   | res_valid_o strobe | res_o    | out
//
// Decimal modes: bit-serial double dabble conversion, a handoff into the skip state,
// then leading zero digits dropped one by one, then the sign (if any) and each digit sent.
// Hex and pointer modes skip the conversion.
// One request at a time; busy_o stays high until its last character has gone out.
// Results are strobed for one cycle each and cannot be stalled.
// rst_ni clears the control state; an unused mode is taken and dropped.
module integer_to_ascii_formatter_core #(
  parameter int unsigned POINTER_BITS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  itaf_pkg::req_t req_i,
  output logic           busy_o,
  output logic           res_valid_o,
  output itaf_pkg::rsp_t res_o
);
  import itaf_pkg::*;

  localparam int unsigned PTR_DIGITS = (POINTER_BITS + 3) / 4;
  localparam int unsigned PTR_SHIFT  = VALUE_W - 4 * PTR_DIGITS;

  state_e state_q, state_d;
  pfx_e   pfx_q, pfx_d;
  logic [2:0]         pidx_q, pidx_d;
  logic [4:0]         ndig_q, ndig_d;
  logic               upper_q, upper_d;
  logic [VALUE_W-1:0] dig_q, dig_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d, cnt_inc;

  logic               accept;
  logic               conv_start, conv_done;
  logic [DEC_BITS-1:0] low, mag;
  logic [BCD_W-1:0]   bcd;
  logic [VALUE_W-1:0] ptr_mask, ptr_val;
  logic [3:0]         digit;
  logic [7:0]         digit_ch;

  assign accept  = start_i && !busy_o;
  assign low     = req_i.value[DEC_BITS-1:0];
  assign mag     = (req_i.mode == MODE_SDEC && low[DEC_BITS-1]) ? (~low + 1'b1) : low;
  assign conv_start = accept && (req_i.mode == MODE_SDEC || req_i.mode == MODE_UDEC);

  always_comb begin
    for (int i = 0; i < VALUE_W; i++) begin
      ptr_mask[i] = (i < POINTER_BITS);
    end
  end
  assign ptr_val = req_i.value & ptr_mask;

  itaf_bcd_conv u_bcd_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .bin_i   (mag),
    .done_o  (conv_done),
    .bcd_o   (bcd)
  );

  assign digit    = dig_q[VALUE_W-1 -: 4];
  assign digit_ch = (digit < 4'd10) ? CH_ZERO + {4'd0, digit}
                  : (upper_q ? CH_UPA : CH_LOWA) + {4'd0, digit} - 8'd10;
  assign cnt_inc  = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    state_d = state_q;
    pfx_d   = pfx_q;
    pidx_d  = pidx_q;
    ndig_d  = ndig_q;
    upper_d = upper_q;
    dig_d   = dig_q;
    cnt_d   = cnt_q;
    res_valid_o     = 1'b0;
    res_o.char_code = digit_ch;
    res_o.count_out = cnt_inc;
    res_o.last_char = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d   = req_i.count_in;
          pidx_d  = '0;
          upper_d = (req_i.mode == MODE_HEXU);
          priority if (req_i.mode == MODE_SDEC || req_i.mode == MODE_UDEC) begin
            pfx_d   = (req_i.mode == MODE_SDEC && low[DEC_BITS-1]) ? PFX_MINUS : PFX_NONE;
            ndig_d  = 5'(BCD_DIGITS);
            state_d = ST_CONV;
          end else if (req_i.mode == MODE_HEXL || req_i.mode == MODE_HEXU) begin
            pfx_d   = PFX_NONE;
            dig_d   = {low, {(VALUE_W-DEC_BITS){1'b0}}};
            ndig_d  = 5'(DEC_BITS / 4);
            state_d = ST_SKIP;
          end else if (req_i.mode == MODE_PTR) begin
            if (ptr_val == '0) begin
              pfx_d   = PFX_NIL;
              ndig_d  = '0;
              state_d = ST_PREFIX;
            end else begin
              pfx_d   = PFX_HEX;
              dig_d   = ptr_val << PTR_SHIFT;
              ndig_d  = 5'(PTR_DIGITS);
              state_d = ST_SKIP;
            end
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          dig_d   = {bcd, {(VALUE_W-BCD_W){1'b0}}};
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (digit == 4'd0 && ndig_q > 5'd1) begin
          dig_d  = dig_q << 4;
          ndig_d = ndig_q - 1'b1;
        end else begin
          state_d = (pfx_q == PFX_NONE) ? ST_EMIT : ST_PREFIX;
        end
      end
      ST_PREFIX: begin
        res_valid_o     = 1'b1;
        res_o.char_code = pfx_char(pfx_q, pidx_q);
        res_o.last_char = (pfx_q == PFX_NIL) && (pidx_q == pfx_len(pfx_q) - 1'b1);
        cnt_d  = cnt_inc;
        pidx_d = pidx_q + 1'b1;
        if (pidx_q == pfx_len(pfx_q) - 1'b1) begin
          state_d = (pfx_q == PFX_NIL) ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        res_valid_o     = 1'b1;
        res_o.last_char = (ndig_q == 5'd1);
        cnt_d  = cnt_inc;
        dig_d  = dig_q << 4;
        ndig_d = ndig_q - 1'b1;
        if (ndig_q == 5'd1) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pfx_q   <= pfx_d;
    pidx_q  <= pidx_d;
    ndig_q  <= ndig_d;
    upper_q <= upper_d;
    dig_q   <= dig_d;
    cnt_q   <= cnt_d;
  end

  assign busy_o = (state_q != ST_IDLE);

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy_o) else $error("result strobe while idle");

  a_conv_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_done |-> state_q == ST_CONV) else $error("conversion done outside CONV");

  a_emit_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> ndig_q != 5'd0) else $error("emit with no digits left");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_char |=> !busy_o) else $error("busy after last character");

  a_bad_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.mode > MODE_PTR |=> !busy_o) else $error("unused mode not dropped");

endmodule
